// ===== design/pkwrl_pkg.sv =====
// ----------------------------------------------------------------------------
// pkwrl_pkg
// Shared types and constants of the per-key window rate limiter.
// ----------------------------------------------------------------------------
package pkwrl_pkg;

  localparam int unsigned LEN_W   = 8;
  localparam int unsigned LIMIT_W = 20;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned OUT_W   = 3;

  // low 16 bits of the FNV-1a 64-bit constants; the prime's upper term is 2^40
  localparam logic [15:0] FNV_BASIS_LO = 16'h2325;
  localparam logic [15:0] FNV_PRIME_LO = 16'h01b3;

  localparam logic [TIME_W-1:0] WINDOW_MS = 32'd1000;

  typedef enum logic [OUT_W-1:0] {
    OUT_DISABLED = 3'd0,
    OUT_NEW_SLOT = 3'd1,
    OUT_WITHIN   = 3'd2,
    OUT_OVER     = 3'd3,
    OUT_EXHAUST  = 3'd4
  } outcome_e;

  typedef struct packed {
    logic               used;
    logic [LEN_W-1:0]   key_len;
    logic [TIME_W-1:0]  win_start;
    logic [LIMIT_W-1:0] count;
  } slot_meta_t;

endpackage

// ===== design/per_key_window_rate_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// per_key_window_rate_limiter_unit
// Per-key fixed-window rate limiter with a linearly probed slot table.
// ----------------------------------------------------------------------------
// Flow: with limiting off, a final byte goes straight to the result; else each
//   probe reads a slot, compares key bytes on a length match, and ends in a claim (key copy) or an update.
// Throughput: one byte per cycle while gathering; the probe/compare sequencer,
//   one byte at a time on the shared key memory port, sets the rest.
// Reset: state and limit clear at once; a clearing pass then marks every slot
//   free, taking no input (config writes still accepted).
module per_key_window_rate_limiter_unit #(
  parameter int unsigned SLOTS     = 4096,  // power of two, 16..65536
  parameter int unsigned MAX_PROBE = 32,
  parameter int unsigned KEY_MAX   = 255
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pkwrl_pkg::LIMIT_W-1:0] limit_per_second_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  subject_byte_i,
  input  logic                        last_byte_i,
  input  logic [31:0]                 now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        allowed_o,
  output logic [2:0]                  outcome_o
);
  import pkwrl_pkg::*;

  localparam int unsigned HW = $clog2(SLOTS);
  localparam int unsigned SW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned KA = $clog2(SLOTS * KEY_MAX);
  localparam int unsigned PW = $clog2(MAX_PROBE + 1);
  localparam logic [HW-1:0] BASIS_L = HW'(FNV_BASIS_LO);
  localparam logic [HW-1:0] PRIME_L = HW'(FNV_PRIME_LO);

  // sequencer states
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_PROBE  = 4'd2;
  localparam logic [3:0] ST_CHECK  = 4'd3;
  localparam logic [3:0] ST_CMP_RD = 4'd4;
  localparam logic [3:0] ST_CMP_CK = 4'd5;
  localparam logic [3:0] ST_CPY_RD = 4'd6;
  localparam logic [3:0] ST_CPY_WR = 4'd7;
  localparam logic [3:0] ST_UPDATE = 4'd8;
  localparam logic [3:0] ST_RESULT = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [HW-1:0]      hash_q, hash_d;
  logic [HW-1:0]      slot_q, slot_d;
  logic [HW-1:0]      clr_q, clr_d;
  logic [PW-1:0]      probe_q, probe_d;
  logic [LEN_W-1:0]   idx_q, idx_d;
  logic [KA-1:0]      key_base_q;
  logic [TIME_W-1:0]  now_q, now_d;
  logic               res_allow_q, res_allow_d;
  outcome_e           res_out_q, res_out_d;
  logic               out_valid_q, out_valid_d;
  logic               out_allow_q;
  outcome_e           out_code_q;

  // memories
  logic [7:0]  subj_mem [KEY_MAX];
  logic [7:0]  key_mem  [SLOTS*KEY_MAX];
  slot_meta_t  meta_mem [SLOTS];
  logic [7:0]  subj_rd_q, key_rd_q;
  slot_meta_t  meta_rd_q;
  logic        subj_we, key_we, meta_we;
  slot_meta_t  meta_wd;
  logic [HW-1:0] meta_wa;
  logic [KA-1:0] key_addr;

  logic        in_xfer, store_byte;
  logic [HW-1:0] hash_x;
  logic        expired;
  logic [LIMIT_W-1:0] cnt_eff;
  logic [TIME_W-1:0]  ws_eff;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign store_byte  = (subject_byte_i != 8'd0) && (len_q < LEN_W'(KEY_MAX));
  assign hash_x      = hash_q ^ HW'(subject_byte_i);
  assign key_addr    = key_base_q + KA'(idx_q);

  // window check for a matched slot
  assign expired = (now_q - meta_rd_q.win_start) >= WINDOW_MS;
  assign cnt_eff = expired ? '0 : meta_rd_q.count;
  assign ws_eff  = expired ? now_q : meta_rd_q.win_start;

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    hash_d      = hash_q;
    slot_d      = slot_q;
    clr_d       = clr_q;
    probe_d     = probe_q;
    idx_d       = idx_q;
    now_d       = now_q;
    res_allow_d = res_allow_q;
    res_out_d   = res_out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    subj_we     = 1'b0;
    key_we      = 1'b0;
    meta_we     = 1'b0;
    meta_wa     = slot_q;
    meta_wd     = meta_rd_q;
    unique case (state_q)
      ST_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_q;
        meta_wd = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == HW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (store_byte) begin
            subj_we = 1'b1;
            len_d   = len_q + 1'b1;
            hash_d  = hash_x * PRIME_L;
          end
          if (last_byte_i) begin
            now_d   = now_ms_i;
            slot_d  = hash_d;
            probe_d = '0;
            idx_d   = '0;
            if (limit_q == '0) begin
              res_allow_d = 1'b1;
              res_out_d   = OUT_DISABLED;
              state_d     = ST_RESULT;
            end else begin
              state_d = ST_PROBE;
            end
          end
        end
      end
      ST_PROBE: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!meta_rd_q.used) begin
          // free slot: claim it, then copy the key in
          meta_we     = 1'b1;
          meta_wd     = '{used: 1'b1, key_len: len_q, win_start: now_q,
                          count: LIMIT_W'(1)};
          res_allow_d = 1'b1;
          res_out_d   = OUT_NEW_SLOT;
          state_d     = (len_q == '0) ? ST_RESULT : ST_CPY_RD;
        end else if (meta_rd_q.key_len == len_q) begin
          state_d = (len_q == '0) ? ST_UPDATE : ST_CMP_RD;
        end else begin
          probe_d = probe_q + 1'b1;
          slot_d  = slot_q + 1'b1;
          if (probe_q == PW'(MAX_PROBE - 1)) begin
            res_allow_d = 1'b1;
            res_out_d   = OUT_EXHAUST;
            state_d     = ST_RESULT;
          end else begin
            state_d = ST_PROBE;
          end
        end
      end
      ST_CMP_RD: begin
        state_d = ST_CMP_CK;
      end
      ST_CMP_CK: begin
        if (subj_rd_q != key_rd_q) begin
          idx_d   = '0;
          probe_d = probe_q + 1'b1;
          slot_d  = slot_q + 1'b1;
          if (probe_q == PW'(MAX_PROBE - 1)) begin
            res_allow_d = 1'b1;
            res_out_d   = OUT_EXHAUST;
            state_d     = ST_RESULT;
          end else begin
            state_d = ST_PROBE;
          end
        end else if (idx_q == len_q - 1'b1) begin
          state_d = ST_UPDATE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_CMP_RD;
        end
      end
      ST_CPY_RD: begin
        state_d = ST_CPY_WR;
      end
      ST_CPY_WR: begin
        key_we = 1'b1;
        idx_d  = idx_q + 1'b1;
        state_d = (idx_q == len_q - 1'b1) ? ST_RESULT : ST_CPY_RD;
      end
      ST_UPDATE: begin
        meta_we           = 1'b1;
        meta_wd.win_start = ws_eff;
        if (cnt_eff < limit_q) begin
          meta_wd.count = cnt_eff + 1'b1;
          res_allow_d   = 1'b1;
          res_out_d     = OUT_WITHIN;
        end else begin
          meta_wd.count = cnt_eff;
          res_allow_d   = 1'b0;
          res_out_d     = OUT_OVER;
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          len_d       = '0;
          hash_d      = BASIS_L;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      limit_q     <= '0;
      len_q       <= '0;
      hash_q      <= BASIS_L;
      clr_q       <= '0;
      probe_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      hash_q      <= hash_d;
      clr_q       <= clr_d;
      probe_q     <= probe_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= limit_per_second_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    now_q       <= now_d;
    res_allow_q <= res_allow_d;
    res_out_q   <= res_out_d;
    key_base_q  <= KA'(slot_q * KEY_MAX);
    if (state_q == ST_RESULT && state_d == ST_IDLE) begin
      out_allow_q <= res_allow_q;
      out_code_q  <= res_out_q;
    end
  end

  // synchronous memories, registered read data
  always_ff @(posedge clk_i) begin
    if (subj_we) begin
      subj_mem[len_q[SW-1:0]] <= subject_byte_i;
    end
    subj_rd_q <= subj_mem[idx_q[SW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_addr] <= subj_rd_q;
    end
    key_rd_q <= key_mem[key_addr];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    meta_rd_q <= meta_mem[slot_q];
  end

  assign out_valid_o = out_valid_q;
  assign allowed_o   = out_allow_q;
  assign outcome_o   = out_code_q;

`ifndef ASSERT_OFF
  a_no_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_ready_o) else $error("input taken during clear");
  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(KEY_MAX)) else $error("subject length overflow");
  a_probe_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PROBE |-> probe_q < PW'(MAX_PROBE)) else $error("probe overrun");
  a_over_deny: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == OUT_OVER |-> !allowed_o) else $error("over but allowed");
`endif

endmodule

// ===== bench/tb_per_key_window_rate_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_per_key_window_rate_limiter_unit
// Self-checking bench: streams subject bytes with random gaps and output
// back-pressure, predicts each allow/deny decision from a behavioral copy of
// the hashed slot table, and compares every result transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_per_key_window_rate_limiter_unit;

  import pkwrl_pkg::*;

  localparam int unsigned NSLOT     = 4096;
  localparam int unsigned NPROBE    = 32;
  localparam int unsigned KEYCAP    = 255;
  localparam int unsigned STALL_MAX = 60000;  // cycles with no transfer at all

  typedef bit [7:0] key_q_t[$];

  typedef struct {
    logic     allowed;
    outcome_e outcome;
  } verdict_t;

  // --------------------------------------------------------------------------
  // Scoreboard: behavioral slot table plus the queue of pending verdicts.
  // --------------------------------------------------------------------------
  class rl_scoreboard;
    bit [LIMIT_W-1:0] limit;
    bit [63:0]        hash;
    key_q_t           subj_q;
    bit               used[NSLOT];
    key_q_t           slot_key[NSLOT];
    bit [31:0]        win_start[NSLOT];
    bit [LIMIT_W-1:0] count[NSLOT];
    verdict_t         verdict_q[$];
    int               errors;

    function new();
      limit  = '0;
      hash   = 64'hcbf29ce484222325;
      errors = 0;
      foreach (used[i]) begin
        used[i]  = 1'b0;
        count[i] = '0;
      end
    endfunction

    function int unsigned slot_index(key_q_t k);
      bit [63:0] h;
      h = 64'hcbf29ce484222325;
      foreach (k[i]) h = (h ^ {56'd0, k[i]}) * 64'h100000001b3;
      return 32'(h % NSLOT);
    endfunction

    // table lookup on the end of a subject
    function verdict_t decide(bit [31:0] now);
      verdict_t    v;
      int unsigned s;
      if (limit == 0) begin
        v.allowed = 1'b1; v.outcome = OUT_DISABLED;
        return v;
      end
      for (int p = 0; p < NPROBE; p++) begin
        s = 32'(((hash % NSLOT) + 64'(p)) % NSLOT);
        if (!used[s]) begin
          used[s]      = 1'b1;
          slot_key[s]  = subj_q;
          win_start[s] = now;
          count[s]     = LIMIT_W'(1);
          v.allowed = 1'b1; v.outcome = OUT_NEW_SLOT;
          return v;
        end
        if (slot_key[s] != subj_q) continue;
        if (32'(now - win_start[s]) >= WINDOW_MS) begin
          win_start[s] = now;
          count[s]     = '0;
        end
        if (count[s] < limit) begin
          count[s]  = count[s] + 1'b1;
          v.allowed = 1'b1; v.outcome = OUT_WITHIN;
        end else begin
          v.allowed = 1'b0; v.outcome = OUT_OVER;
        end
        return v;
      end
      v.allowed = 1'b1; v.outcome = OUT_EXHAUST;
      return v;
    endfunction

    function void note_item(bit [7:0] b, bit last, bit [31:0] now);
      if (b != 0 && subj_q.size() < KEYCAP) begin
        subj_q.push_back(b);
        hash = (hash ^ {56'd0, b}) * 64'h100000001b3;
      end
      if (last) begin
        verdict_q.push_back(decide(now));
        subj_q.delete();
        hash = 64'hcbf29ce484222325;
      end
    endfunction

    function void check_result(logic allowed, logic [OUT_W-1:0] outcome);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result allowed=%0b outcome=%0d", $time, allowed, outcome);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (allowed !== v.allowed) begin
        $display("%0t: allowed expected %0b actual %0b", $time, v.allowed, allowed);
        errors++;
      end
      if (outcome !== v.outcome) begin
        $display("%0t: outcome expected %0d actual %0d", $time, v.outcome, outcome);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [LIMIT_W-1:0] limit_per_second_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         subject_byte_i;
  logic               last_byte_i;
  logic [31:0]        now_ms_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               allowed_o;
  logic [2:0]         outcome_o;

  per_key_window_rate_limiter_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .limit_per_second_i (limit_per_second_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .subject_byte_i     (subject_byte_i),
    .last_byte_i        (last_byte_i),
    .now_ms_i           (now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .allowed_o          (allowed_o),
    .outcome_o          (outcome_o)
  );

  rl_scoreboard sb = new();

  bit          idle_en = 1'b1;  // random gaps on both sides
  bit          hold_req;        // asks the receiver for one long hold-off
  int unsigned items_sent;
  bit [31:0]   clock_ms;
  int unsigned quiet_cycles = 0;
  key_q_t      key_pool[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off counted here so that the
  // block fills up and pushes back on its input.
  initial begin
    int unsigned hold_cnt;
    bit          hold_done;
    hold_cnt    = 0;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt  = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(idle_en && $urandom_range(99) < 10);
      end
    end
  end

  // Result monitor: values sampled at the edge are the pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(allowed_o, outcome_o);
  end

  // Watchdog on progress of any channel; the clearing pass after reset
  // accepts config transfers only, so the limit covers it.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > STALL_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  // One byte transfer. Valid is only dropped when a gap is taken, so it is
  // never lowered and raised in the same step.
  task automatic send_byte(bit [7:0] b, bit last, bit [31:0] now);
    if (idle_en && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    in_valid_i     <= 1'b1;
    subject_byte_i <= b;
    last_byte_i    <= last;
    now_ms_i       <= now;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(b, last, now);
    items_sent++;
  endtask

  // Whole subject; time only matters on the final byte.
  task automatic send_subject(key_q_t k, bit [31:0] now);
    foreach (k[i]) send_byte(k[i], i == k.size() - 1, (i == k.size() - 1) ? now : $urandom);
  endtask

  // Wait until every pending verdict has come back, then settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_limit(bit [LIMIT_W-1:0] v);
    drain();
    cfg_valid_i        <= 1'b1;
    limit_per_second_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.limit = v;
  endtask

  function automatic key_q_t rand_key(int unsigned len);
    key_q_t k;
    repeat (len) k.push_back(8'($urandom_range(1, 255)));
    return k;
  endfunction

  function automatic key_q_t fill_key(bit [7:0] b, int unsigned len);
    key_q_t k;
    repeat (len) k.push_back(b);
    return k;
  endfunction

  // Mostly small steps so windows stay open; rare big jumps across the range.
  function automatic bit [31:0] tick();
    if ($urandom_range(99) < 5) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 350);
    return clock_ms;
  endfunction

  // Random phase over a small pool of short keys so that repeats are frequent.
  task automatic random_phase(int unsigned n_items);
    int unsigned stop_at;
    key_q_t      k;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15 || key_pool.size() == 0) begin
        k = rand_key($urandom_range(1, 8));
        if (key_pool.size() < 16) key_pool.push_back(k);
      end else begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      send_subject(k, tick());
    end
  endtask

  // Keys that all hash to one base slot fill the probe window and then run
  // out of probes.
  task automatic collision_phase();
    key_q_t      k;
    key_q_t      group[$];
    int unsigned base;
    bit          dup;
    k    = rand_key(3);
    base = sb.slot_index(k);
    group.push_back(k);
    while (group.size() < NPROBE + 3) begin
      k = rand_key(3);
      if (sb.slot_index(k) != base) continue;
      dup = 1'b0;
      foreach (group[i]) if (group[i] == k) dup = 1'b1;
      if (!dup) group.push_back(k);
    end
    foreach (group[i]) send_subject(group[i], tick());
    // revisit the deepest keys: long probe, then match or exhaustion
    for (int i = group.size() - 4; i < group.size(); i++) send_subject(group[i], tick());
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    key_q_t k_a;
    key_q_t k_long;
    cfg_valid_i        = 1'b0;
    limit_per_second_i = '0;
    in_valid_i         = 1'b0;
    subject_byte_i     = 8'd0;
    last_byte_i        = 1'b0;
    now_ms_i           = '0;
    hold_req           = 1'b0;
    items_sent         = 0;
    clock_ms           = 32'hFFFF_F000;
    @(posedge rst_ni);
    @(posedge clk_i);

    // disabled: limit zero after reset always allows
    send_subject(fill_key(8'hFF, 2), 32'hFFFF_FFFF);
    send_subject(fill_key(8'h01, 1), 32'h0);

    // limit of one: claim, deny, window restart across the 32-bit wrap
    write_limit(1);
    k_a = fill_key(8'h5A, 3);
    send_subject(k_a, 32'hFFFF_FE00);
    send_subject(k_a, 32'hFFFF_FFFF);
    send_subject(k_a, 32'h0000_01E7);  // 999 ms after start: still denied
    send_subject(k_a, 32'h0000_01E8);  // exactly one window later
    send_subject(fill_key(8'hFF, 1), 32'h8000_0000);
    send_subject(fill_key(8'h01, 4), 32'h7FFF_FFFF);
    // long subject: bytes past the key capacity are dropped, tails differ
    k_long = rand_key(KEYCAP);
    k_long.push_back(8'hAA);
    send_subject(k_long, 32'h1234_5678);
    k_long[KEYCAP] = 8'h55;
    send_subject(k_long, 32'h1234_5679);

    // large limit of one million; no idling in this stretch
    write_limit(20'd1000000);
    idle_en = 1'b0;
    random_phase(60);
    idle_en = 1'b1;

    // small limit with one long receiver hold-off while input keeps coming
    write_limit(3);
    hold_req = 1'b1;
    random_phase(30);

    write_limit(2);
    collision_phase();
    random_phase(20);

    write_limit(0);
    random_phase(10);

    write_limit(1);
    random_phase(20);

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.verdict_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pkwrl_pkg.sv
design/per_key_window_rate_limiter_unit.sv
bench/tb_per_key_window_rate_limiter_unit.sv
